[hdl/pms_pkg.sv]
// Shared types and codes for the periodic message scheduler.
package pms_pkg;

  localparam int ID_W     = 29;
  localparam int IVL_W    = 16;
  localparam int TIME_W   = 48;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  localparam int MAX_ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_SEND     = 3'd0,
    KIND_ADDED    = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_REMOVED  = 3'd3,
    KIND_NOTFOUND = 3'd4,
    KIND_CLEARED  = 3'd5,
    KIND_DONE     = 3'd6
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] last_sent;
  } entry_t;

endpackage

[hdl/pms_due.sv]
// Due check for one table entry: now >= last_sent and elapsed time >= interval.
module pms_due
  import pms_pkg::*;
(
  input  logic [TIME_W-1:0] now,
  input  entry_t            ent,
  output logic              due
);

  logic [TIME_W:0] diff;

  // top bit is the borrow: time went backwards
  assign diff = {1'b0, now} - {1'b0, ent.last_sent};
  assign due  = !diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_W'(ent.interval));

endmodule

[hdl/periodic_message_scheduler.sv]
// Periodic message scheduler: entry table in one RAM, walked by a small sequencer.
//
// Input channel (in_valid/in_stall) takes one operation: tick, add, remove or clear.
// Output channel (out_valid/out_stall) returns one or more results per operation;
// the final result of each operation has last set. in_stall is high while an
// operation is in progress, so a new operation is taken only once the previous
// one has produced its final result into the output register.
// Add and clear go straight to FIN, which loads their result into the output
// register once that is free and returns to IDLE. A tick with the link up, or a
// remove, on a table of N entries walks all N, one RAM read per entry overlapped
// with the due check or move-down of the entry read before, then loads its final
// result from FIN. Empty tables and ticks with the link down go straight to FIN.
// Sustained rate is set by that walk, one entry per cycle through the RAM's read
// port while no pending send is held by a receiver stall.
// When the receiver stalls, a pending send holds the walk in place; the output
// register keeps its result until it is taken.
// Reset (rst, synchronous) empties the table and drops any pending result; the
// RAM contents are not cleared, entries beyond the count are never read.
module periodic_message_scheduler
  import pms_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [ID_W-1:0]    msg_id,
  input  logic [IVL_W-1:0]   interval_ms,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic               link_up,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [ID_W-1:0]    out_id,
  output logic [SLOT_W-1:0]  slot,
  output logic [COUNT_W-1:0] entry_count,
  output logic               last
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    IDLE,
    TICK_EV,
    RM_EV,
    SHIFT_EV,
    FIN
  } state_t;

  state_t state;

  // entry table
  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_p1;
  logic [CNT_W-1:0] ptr_m1;
  logic [ID_W-1:0]  id_r;
  logic [TIME_W-1:0] now_r;

  kind_t             fin_kind;
  logic [ID_W-1:0]   fin_id;
  logic [SLOT_W-1:0] fin_slot;

  kind_t             out_kind;

  logic accept;
  logic out_free;
  logic out_load;
  logic due;
  logic more;
  logic has_room;
  logic id_match;
  logic hold;
  op_t  op_in;

  assign op_in    = op_t'(opcode);
  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == TICK_EV) && due && out_free) || ((state == FIN) && out_free);
  assign ptr_p1   = ptr + CNT_W'(1);
  assign ptr_m1   = ptr - CNT_W'(1);
  assign more     = (ptr_p1 < count);
  assign has_room = (count < CNT_W'(MAX_ENTRIES));
  assign id_match = (rd_data.id == id_r);
  assign hold     = due && !out_free;
  assign kind     = out_kind;

  pms_due u_due (
    .now (now_r),
    .ent (rd_data),
    .due (due)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // RAM port control. Reads run one entry ahead of writes, so the same entry is
  // never read and written in one cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_p1[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[IDX_W-1:0];
    wr_data = rd_data;
    unique case (state)
      IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_TICK: begin
              rd_en   = link_up && (count != '0);
              rd_addr = '0;
            end
            OP_ADD: begin
              wr_en   = has_room;
              wr_addr = count[IDX_W-1:0];
              wr_data = '{id: msg_id, interval: interval_ms, last_sent: '0};
            end
            OP_REMOVE: begin
              rd_en   = (count != '0);
              rd_addr = '0;
            end
            OP_CLEAR: begin
            end
            default: begin
            end
          endcase
        end
      end
      TICK_EV: begin
        if (!hold) begin
          rd_en             = more;
          wr_en             = due;
          wr_data.last_sent = now_r;
        end
      end
      RM_EV: begin
        rd_en = more;
      end
      SHIFT_EV: begin
        wr_en   = 1'b1;
        wr_addr = ptr_m1[IDX_W-1:0];
        rd_en   = more;
      end
      FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        IDLE: begin
          if (accept) begin
            id_r  <= msg_id;
            now_r <= now_ms;
            ptr   <= '0;
            state <= FIN;
            unique case (op_in)
              OP_TICK: begin
                fin_kind <= KIND_DONE;
                fin_id   <= '0;
                fin_slot <= '0;
                if (link_up && (count != '0)) begin
                  state <= TICK_EV;
                end
              end
              OP_ADD: begin
                fin_id <= msg_id;
                if (has_room) begin
                  fin_kind <= KIND_ADDED;
                  fin_slot <= SLOT_W'(count);
                  count    <= count + CNT_W'(1);
                end else begin
                  fin_kind <= KIND_FULL;
                  fin_slot <= '0;
                end
              end
              OP_REMOVE: begin
                fin_kind <= KIND_NOTFOUND;
                fin_id   <= msg_id;
                fin_slot <= '0;
                if (count != '0) begin
                  state <= RM_EV;
                end
              end
              OP_CLEAR: begin
                fin_kind <= KIND_CLEARED;
                fin_id   <= '0;
                fin_slot <= '0;
                count    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        TICK_EV: begin
          if (!hold) begin
            if (due) begin
              out_kind    <= KIND_SEND;
              out_id      <= rd_data.id;
              slot        <= SLOT_W'(ptr);
              entry_count <= COUNT_W'(count);
              last        <= 1'b0;
            end
            if (more) begin
              ptr <= ptr_p1;
            end else begin
              state <= FIN;
            end
          end
        end
        RM_EV: begin
          if (id_match) begin
            fin_kind <= KIND_REMOVED;
            fin_slot <= SLOT_W'(ptr);
            if (more) begin
              ptr   <= ptr_p1;
              state <= SHIFT_EV;
            end else begin
              count <= count - CNT_W'(1);
              state <= FIN;
            end
          end else if (more) begin
            ptr <= ptr_p1;
          end else begin
            state <= FIN;
          end
        end
        SHIFT_EV: begin
          // rd_data holds entry ptr; it moves down to ptr - 1
          if (more) begin
            ptr <= ptr_p1;
          end else begin
            count <= count - CNT_W'(1);
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            out_kind    <= fin_kind;
            out_id      <= fin_id;
            slot        <= fin_slot;
            entry_count <= COUNT_W'(count);
            last        <= 1'b1;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // a non-final result means the operation is still in progress
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("non-final result while input is open");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_send_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_SEND) |-> !last)
    else $error("send result marked final");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (op_in == OP_CLEAR) |=> (count == '0))
    else $error("clear left entries in table");

endmodule

[sim/periodic_message_scheduler_tb.sv]
// Self-checking testbench for the periodic message scheduler.
module periodic_message_scheduler_tb;
  import pms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ID_W-1:0]   ID_MAX   = '1;
  localparam logic [IVL_W-1:0]  IVL_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

  typedef struct {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  ivl;
    logic [TIME_W-1:0] now;
    logic              link;
  } sched_op_t;

  typedef struct {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic               last;
  } report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = OP_TICK;
  logic [ID_W-1:0]    msg_id = '0;
  logic [IVL_W-1:0]   interval_ms = '0;
  logic [TIME_W-1:0]  now_ms = '0;
  logic               link_up = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         kind;
  logic [ID_W-1:0]    out_id;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] entry_count;
  logic               last;

  periodic_message_scheduler u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .msg_id      (msg_id),
    .interval_ms (interval_ms),
    .now_ms      (now_ms),
    .link_up     (link_up),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_id      (out_id),
    .slot        (slot),
    .entry_count (entry_count),
    .last        (last)
  );

  always #10 clk = ~clk;

  // Stimulus and expected reports
  sched_op_t op_queue[$];
  report_t   report_queue[$];

  // Shadow of the scheduler table
  logic [ID_W-1:0]   tbl_id[TABLE_DEPTH];
  logic [IVL_W-1:0]  tbl_ivl[TABLE_DEPTH];
  logic [TIME_W-1:0] tbl_sent[TABLE_DEPTH];
  int                tbl_used = 0;

  logic in_fire = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   errors = 0;
  int   ops_done = 0;
  int   reports_seen = 0;
  int   sends_seen = 0;
  int   full_seen = 0;
  int   miss_seen = 0;

  function automatic void push_report(kind_t k, logic [ID_W-1:0] id, int pos, logic fin);
    report_t r;
    r.kind  = k;
    r.id    = id;
    r.slot  = SLOT_W'(pos);
    r.count = COUNT_W'(tbl_used);
    r.last  = fin;
    report_queue.push_back(r);
  endfunction

  function automatic void run_operation(sched_op_t o);
    int i;
    int j;
    case (o.op)
      OP_TICK: begin
        if (o.link) begin
          for (i = 0; i < tbl_used; i++) begin
            // time going backwards leaves the entry alone
            if (o.now >= tbl_sent[i] && (o.now - tbl_sent[i]) >= tbl_ivl[i]) begin
              tbl_sent[i] = o.now;
              push_report(KIND_SEND, tbl_id[i], i, 1'b0);
            end
          end
        end
        push_report(KIND_DONE, '0, 0, 1'b1);
      end
      OP_ADD: begin
        if (tbl_used < TABLE_DEPTH) begin
          i = tbl_used;
          tbl_id[i]   = o.id;
          tbl_ivl[i]  = o.ivl;
          tbl_sent[i] = '0;
          tbl_used++;
          push_report(KIND_ADDED, o.id, i, 1'b1);
        end else begin
          push_report(KIND_FULL, o.id, 0, 1'b1);
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < tbl_used; i++) begin
          if (tbl_id[i] == o.id) break;
        end
        if (i < tbl_used) begin
          for (j = i; j + 1 < tbl_used; j++) begin
            tbl_id[j]   = tbl_id[j+1];
            tbl_ivl[j]  = tbl_ivl[j+1];
            tbl_sent[j] = tbl_sent[j+1];
          end
          tbl_used--;
          push_report(KIND_REMOVED, o.id, i, 1'b1);
        end else begin
          push_report(KIND_NOTFOUND, o.id, 0, 1'b1);
        end
      end
      default: begin
        tbl_used = 0;
        push_report(KIND_CLEARED, '0, 0, 1'b1);
      end
    endcase
  endfunction

  function automatic void queue_op(op_t op, logic [ID_W-1:0] id, logic [IVL_W-1:0] ivl,
                                   logic [TIME_W-1:0] now, logic link);
    sched_op_t o;
    o.op   = op;
    o.id   = id;
    o.ivl  = ivl;
    o.now  = now;
    o.link = link;
    op_queue.push_back(o);
  endfunction

  // Driver: new transfer offered at the falling edge once the last one was taken
  always @(negedge clk) begin : drv
    sched_op_t nxt;
    if (!rst && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (op_queue.size() != 0) begin
        nxt = op_queue.pop_front();
        opcode      <= nxt.op;
        msg_id      <= nxt.id;
        interval_ms <= nxt.ivl;
        now_ms      <= nxt.now;
        link_up     <= nxt.link;
        in_valid    <= 1'b1;
        // idle bursts come in alternating blocks and stop near the end
        if (op_queue.size() > 40 && (op_queue.size() / 50) % 2 == 0 &&
            $urandom_range(0, 3) == 0)
          in_gap <= $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap   <= out_gap - 1;
    end else if (op_queue.size() > 40 && (op_queue.size() / 37) % 2 == 1 &&
                 $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      out_gap   <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin : mon
    sched_op_t cur;
    report_t   want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        cur.op   = op_t'(opcode);
        cur.id   = msg_id;
        cur.ivl  = interval_ms;
        cur.now  = now_ms;
        cur.link = link_up;
        run_operation(cur);
        ops_done++;
      end
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (kind == KIND_SEND) sends_seen++;
        if (kind == KIND_FULL) full_seen++;
        if (kind == KIND_NOTFOUND) miss_seen++;
        if (report_queue.size() == 0) begin
          $error("unexpected report: kind %0d out_id 0x%0h slot %0d", kind, out_id, slot);
          errors++;
        end else begin
          want = report_queue.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            errors++;
          end
          if (out_id !== want.id) begin
            $error("out_id: expected 0x%0h, got 0x%0h", want.id, out_id);
            errors++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            errors++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [ID_W-1:0]   live_ids[$];
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  ivl;
    logic [TIME_W-1:0] t_gen;
    int n;
    int k;
    int r;

    // directed: empty tick, field extremes, backwards time, full table, remove cases
    queue_op(OP_TICK,   '0,     '0,      '0,       1'b1);
    queue_op(OP_ADD,    '0,     '0,      '0,       1'b0);
    queue_op(OP_ADD,    ID_MAX, IVL_MAX, TIME_MAX, 1'b1);
    queue_op(OP_TICK,   '0,     '0,      '0,       1'b1);
    queue_op(OP_TICK,   ID_MAX, IVL_MAX, TIME_MAX, 1'b1);
    queue_op(OP_TICK,   '0,     '0,      48'd5,    1'b1);
    queue_op(OP_REMOVE, 29'h0abcdef, '0, '0,       1'b0);
    queue_op(OP_REMOVE, ID_MAX, '0,      '0,       1'b0);
    for (k = 1; k < TABLE_DEPTH; k++)
      queue_op(OP_ADD, (k == 9) ? '0 : ID_W'(k * 29'h1111111), IVL_W'(k * 10), '0, 1'b0);
    queue_op(OP_ADD,    29'h1234567, 16'd7, '0,    1'b0);
    queue_op(OP_REMOVE, '0,     '0,      '0,       1'b0);
    queue_op(OP_CLEAR,  ID_MAX, IVL_MAX, TIME_MAX, 1'b1);

    // random: ticks as the largest share, mostly moving forward in time, over a churning table
    t_gen = '0;
    for (n = 0; n < 330; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        k = $urandom_range(0, 99);
        if (k < 4 && t_gen > 50) t_gen = t_gen - $urandom_range(1, 50);
        else if (k < 7) t_gen = t_gen + {16'b0, $urandom};
        else t_gen = t_gen + $urandom_range(0, 30);
        queue_op(OP_TICK, ID_W'($urandom), IVL_W'($urandom), t_gen,
                 $urandom_range(0, 99) < 85);
      end else if (r < 70) begin
        id  = ($urandom_range(0, 1) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 20));
        ivl = ($urandom_range(0, 4) == 0) ? IVL_W'($urandom) : IVL_W'($urandom_range(0, 60));
        queue_op(OP_ADD, id, ivl, TIME_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
        if (live_ids.size() < TABLE_DEPTH) live_ids.push_back(id);
      end else if (r < 93) begin
        if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
          id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else
          id = ID_W'($urandom);
        queue_op(OP_REMOVE, id, IVL_W'($urandom), TIME_W'({$urandom, $urandom}),
                 1'($urandom_range(0, 1)));
        for (k = 0; k < live_ids.size(); k++) begin
          if (live_ids[k] == id) begin
            live_ids.delete(k);
            break;
          end
        end
      end else begin
        queue_op(OP_CLEAR, ID_W'($urandom), IVL_W'($urandom), TIME_W'({$urandom, $urandom}),
                 1'($urandom_range(0, 1)));
        live_ids.delete();
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid || report_queue.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d operations through the scheduler and checked %0d reports.",
             ops_done, reports_seen);
    $display("Reports included %0d sends, %0d table-full rejects and %0d remove misses.",
             sends_seen, full_seen, miss_seen);
    if (errors == 0 && report_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d reports still outstanding", report_queue.size());
    $display("Verification failed");
    $finish;
  end

endmodule
